// ----- hdl/gdfo_pkg.sv -----
// shared constants, request codes, types and helper functions of the depth-first order block
package gdfo_pkg;

  localparam int unsigned MAX_NODES   = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_NODES);
  localparam int unsigned NUM_W       = $clog2(MAX_NODES + 1);
  localparam int unsigned STACK_DEPTH = MAX_NODES * MAX_NODES + MAX_NODES;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SADDR_W     = $clog2(STACK_DEPTH);

  // request codes carried on the input user field
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  typedef logic [MAX_NODES-1:0] row_t;

  // adjacency memory access for one cycle
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_row;
    logic             wr_en;
    logic [IDX_W-1:0] wr_row;
    row_t             wr_data;
    logic             clr;
  } adj_req_t;

  // stack memory access for one cycle
  typedef struct packed {
    logic               rd_en;
    logic [SADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [SADDR_W-1:0] wr_addr;
    logic [IDX_W-1:0]   wr_data;
  } stk_req_t;

  // single set bit at a node index
  function automatic row_t node_bit(input logic [IDX_W-1:0] idx);
    row_t r;
    r      = '0;
    r[idx] = 1'b1;
    return r;
  endfunction

  // bits of the nodes below n
  function automatic row_t node_mask(input logic [NUM_W-1:0] n);
    row_t r;
    for (int unsigned i = 0; i < MAX_NODES; i++) begin
      r[i] = (NUM_W'(i) < n);
    end
    return r;
  endfunction

  // index of the highest set bit
  function automatic logic [IDX_W-1:0] hi_bit(input row_t r);
    logic [IDX_W-1:0] k;
    k = '0;
    for (int unsigned i = 0; i < MAX_NODES; i++) begin
      if (r[i]) begin
        k = IDX_W'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- hdl/gdfo_adj_mem.sv -----
// adjacency row memory with per-row valid bits so that all rows clear at once
module gdfo_adj_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdfo_pkg::adj_req_t req_i,
  output gdfo_pkg::row_t     rd_row_o
);

  gdfo_pkg::row_t                       mem [gdfo_pkg::MAX_NODES];
  gdfo_pkg::row_t                       rd_q;
  logic                                 rd_vld_q;
  logic [gdfo_pkg::MAX_NODES-1:0]       vld_q;

  // row storage, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_row] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_row];
    end
  end

  // row valid bits, cleared all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_row];
      end
    end
  end

  // a row never written since the last clear reads as empty
  assign rd_row_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- hdl/gdfo_stack_mem.sv -----
// pending-node stack memory, one write and one registered read port
module gdfo_stack_mem (
  input  logic                           clk_i,
  input  gdfo_pkg::stk_req_t             req_i,
  output logic [gdfo_pkg::IDX_W-1:0]     rd_data_o
);

  logic [gdfo_pkg::IDX_W-1:0] mem [gdfo_pkg::STACK_DEPTH];
  logic [gdfo_pkg::IDX_W-1:0] rd_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hdl/graph_depth_first_order.sv -----
// top level: request decode, traversal sequencer and result register
// Input stream carries one request per item: tuser[1:0] is the request kind
// (add edge, clear graph, run traversal), tdata holds the two 1-based edge
// endpoints. Output stream gives one visited node per item, 1-based, with
// tlast on the final node of a traversal. cfg_we_i writes node_count.
// A clear is applied while idle; an edge request makes two read-modify-
// write passes over the adjacency memory. A run tries each start candidate
// in turn and pops stack entries; for every visited node it reads the
// adjacency row and pushes the unvisited neighbors one at a time. Both
// memories have a registered read; the stack takes one access per cycle.
// tready is high only while no request is in progress; results of a run are
// produced through a single output register, so a stalled receiver holds
// the sequencer at its next visited node and no result is lost.
// Reset empties the graph (row valid bits), sets node_count to 16 and
// leaves the sequencer idle; no clearing pass is needed.
module graph_depth_first_order (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [4:0] node_a, [9:5] node_b, [15:10] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [4:0] visited_node, [7:5] zero
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W   = gdfo_pkg::IDX_W;
  localparam int unsigned NUM_W   = gdfo_pkg::NUM_W;
  localparam int unsigned LVL_W   = gdfo_pkg::LVL_W;
  localparam int unsigned SADDR_W = gdfo_pkg::SADDR_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR_A     = 4'd1;
  localparam logic [3:0] S_RD_B     = 4'd2;
  localparam logic [3:0] S_WR_B     = 4'd3;
  localparam logic [3:0] S_START    = 4'd4;
  localparam logic [3:0] S_POP      = 4'd5;
  localparam logic [3:0] S_POP_WAIT = 4'd6;
  localparam logic [3:0] S_ROW_WAIT = 4'd7;
  localparam logic [3:0] S_PUSH     = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [4:0]         node_count_q;
  logic [IDX_W-1:0]   a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [NUM_W-1:0]   n_q, n_d;
  logic [NUM_W-1:0]   start_q, start_d;
  logic [NUM_W-1:0]   total_q, total_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  gdfo_pkg::row_t     visited_q, visited_d;
  gdfo_pkg::row_t     pend_q, pend_d;
  logic               out_valid_q;
  logic [NUM_W-1:0]   out_node_q;
  logic               out_last_q;

  gdfo_pkg::adj_req_t adj_req;
  gdfo_pkg::stk_req_t stk_req;
  gdfo_pkg::row_t     adj_row;
  logic [IDX_W-1:0]   stk_node;

  logic               in_acc;
  logic [4:0]         node_a, node_b;
  logic [1:0]         req_type;
  logic               edge_ok;
  logic               out_free;
  logic               emit;
  logic               emit_last;
  logic [IDX_W-1:0]   push_k;

  assign req_type = s_axis_tuser_i;
  assign node_a   = s_axis_tdata_i[4:0];
  assign node_b   = s_axis_tdata_i[9:5];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign edge_ok  = (node_a inside {[5'd1:5'd16]}) && (node_b inside {[5'd1:5'd16]});
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign push_k   = gdfo_pkg::hi_bit(pend_q);
  assign emit_last = ((total_q + NUM_W'(1)) == n_q);

  gdfo_adj_mem u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (adj_req),
    .rd_row_o (adj_row)
  );

  gdfo_stack_mem u_stack (
    .clk_i     (clk_i),
    .req_i     (stk_req),
    .rd_data_o (stk_node)
  );

  // sequencer: edge read-modify-write and depth-first walk
  always_comb begin
    state_d   = state_q;
    a_idx_d   = a_idx_q;
    b_idx_d   = b_idx_q;
    n_d       = n_q;
    start_d   = start_q;
    total_d   = total_q;
    lvl_d     = lvl_q;
    visited_d = visited_q;
    pend_d    = pend_q;
    adj_req   = '0;
    stk_req   = '0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type)
            gdfo_pkg::REQ_ADD: begin
              if (edge_ok) begin
                a_idx_d        = IDX_W'(node_a - 5'd1);
                b_idx_d        = IDX_W'(node_b - 5'd1);
                adj_req.rd_en  = 1'b1;
                adj_req.rd_row = IDX_W'(node_a - 5'd1);
                state_d        = S_WR_A;
              end
            end
            gdfo_pkg::REQ_CLEAR: begin
              adj_req.clr = 1'b1;
            end
            gdfo_pkg::REQ_RUN: begin
              n_d       = (node_count_q > NUM_W'(gdfo_pkg::MAX_NODES)) ?
                          NUM_W'(gdfo_pkg::MAX_NODES) : node_count_q;
              start_d   = '0;
              total_d   = '0;
              lvl_d     = '0;
              visited_d = '0;
              state_d   = S_START;
            end
            default: begin
            end
          endcase
        end
      end
      S_WR_A: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_row  = a_idx_q;
        adj_req.wr_data = adj_row | gdfo_pkg::node_bit(b_idx_q);
        state_d         = S_RD_B;
      end
      S_RD_B: begin
        adj_req.rd_en  = 1'b1;
        adj_req.rd_row = b_idx_q;
        state_d        = S_WR_B;
      end
      S_WR_B: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_row  = b_idx_q;
        adj_req.wr_data = adj_row | gdfo_pkg::node_bit(a_idx_q);
        state_d         = S_IDLE;
      end
      S_START: begin
        if (total_q == n_q || start_q == n_q) begin
          state_d = S_IDLE;
        end else if (visited_q[start_q[IDX_W-1:0]]) begin
          start_d = start_q + NUM_W'(1);
        end else begin
          stk_req.wr_en   = 1'b1;
          stk_req.wr_addr = lvl_q[SADDR_W-1:0];
          stk_req.wr_data = start_q[IDX_W-1:0];
          lvl_d           = lvl_q + LVL_W'(1);
          state_d         = S_POP;
        end
      end
      S_POP: begin
        if (lvl_q == '0 || total_q == n_q) begin
          start_d = start_q + NUM_W'(1);
          state_d = S_START;
        end else begin
          stk_req.rd_en   = 1'b1;
          stk_req.rd_addr = SADDR_W'(lvl_q - LVL_W'(1));
          lvl_d           = lvl_q - LVL_W'(1);
          state_d         = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        if (visited_q[stk_node]) begin
          state_d = S_POP;
        end else if (out_free) begin
          emit                = 1'b1;
          visited_d[stk_node] = 1'b1;
          total_d             = total_q + NUM_W'(1);
          adj_req.rd_en       = 1'b1;
          adj_req.rd_row      = stk_node;
          state_d             = S_ROW_WAIT;
        end
      end
      S_ROW_WAIT: begin
        pend_d  = adj_row & ~visited_q & gdfo_pkg::node_mask(n_q);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (pend_q == '0) begin
          state_d = S_POP;
        end else begin
          if (lvl_q < LVL_W'(gdfo_pkg::STACK_DEPTH)) begin
            stk_req.wr_en   = 1'b1;
            stk_req.wr_addr = lvl_q[SADDR_W-1:0];
            stk_req.wr_data = push_k;
            lvl_d           = lvl_q + LVL_W'(1);
          end
          pend_d[push_k] = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= 5'd16;
      n_q          <= '0;
      start_q      <= '0;
      total_q      <= '0;
      lvl_q        <= '0;
      visited_q    <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      start_q   <= start_d;
      total_q   <= total_d;
      lvl_q     <= lvl_d;
      visited_q <= visited_d;
      pend_q    <= pend_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // edge endpoints and result payload
  always_ff @(posedge clk_i) begin
    a_idx_q <= a_idx_d;
    b_idx_q <= b_idx_d;
    if (emit) begin
      out_node_q <= {1'b0, stk_node} + NUM_W'(1);
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_node_q};
  assign m_axis_tlast_o  = out_last_q;

  // a result is only loaded when the output register can take it
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over a pending result");

  // visited set and visited count stay in step
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(visited_q) == 32'(total_q))
    else $error("visited count does not match visited set");

  // the stack never grows past its depth
  a_stack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_W'(gdfo_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");

  // a flagged final result leaves every node of the run visited
  a_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (total_q == n_q))
    else $error("final result before all nodes visited");

  // nodes are never visited beyond the node count
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ((visited_q & ~gdfo_pkg::node_mask(n_q)) == '0))
    else $error("node outside the run visited");

endmodule
